// File: rtl/prq_pkg.sv
// Shared constants, codes and types of the priority run-queue scheduler.
package prq_pkg;

    // Fixed field widths
    localparam int ID_W     = 5;
    localparam int PRIO_W   = 5;
    localparam int STATUS_W = 3;

    // Default sizes
    localparam int LEVELS_DEF  = 32;
    localparam int THREADS_DEF = 32;

    // Operation codes
    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_READY  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_LOCKED   = 3'd0,
        ST_KEPT     = 3'd1,
        ST_SWITCHED = 3'd2,
        ST_IDLE     = 3'd3,
        ST_READY    = 3'd4
    } t_status;

endpackage

// File: rtl/prq_cmd_if.sv
// Command and response channel interfaces of the priority run-queue scheduler.
interface prq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [prq_pkg::ID_W-1:0]    thread_id;
    logic [prq_pkg::PRIO_W-1:0]  priority_req;
    logic                        yield;
    logic                        sched_locked;
    logic                        current_running;

    modport source (
        output valid, operation, thread_id, priority_req, yield, sched_locked,
               current_running,
        input  ready
    );
    modport sink (
        input  valid, operation, thread_id, priority_req, yield, sched_locked,
               current_running,
        output ready
    );
endinterface

interface prq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [prq_pkg::STATUS_W-1:0]  status;
    logic [prq_pkg::ID_W-1:0]      next_thread;
    logic                          thread_valid;

    modport source (
        output valid, status, next_thread, thread_valid,
        input  ready
    );
    modport sink (
        input  valid, status, next_thread, thread_valid,
        output ready
    );
endinterface

// File: rtl/priority_run_queue_scheduler.sv
// Priority run-queue scheduler: bitmap level search over per-level linked FIFOs in memory.
//
//   channel  | dir | beat contents
//   ---------+-----+-------------------------------------------------------------
//   i_cmd    | in  | operation, thread_id, priority_req, yield, sched_locked,
//            |     | current_running
//   o_rsp    | out | status, next_thread, thread_valid
//
// One item at a time. The work runs from accept to the result loading the
// output register as a chain of registered reads of the level memory
// (head, tail) and the thread memory (link, level): requeue tail insert, then
// head pop. Reset is synchronous and needs no clearing pass; queue memories
// are meaningful only under set ready bits. A stalled output holds its beat;
// the next command is taken meanwhile and waits for the output register
// before its result is loaded.
module priority_run_queue_scheduler #(
    parameter int LEVELS  = prq_pkg::LEVELS_DEF,
    parameter int THREADS = prq_pkg::THREADS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prq_cmd_if.sink       i_cmd,
    prq_rsp_if.source     o_rsp
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = $clog2(THREADS);
    localparam int IW = prq_pkg::ID_W;

    typedef struct packed {
        logic [IW-1:0] head;
        logic [IW-1:0] tail;
    } t_lvl_word;

    typedef struct packed {
        logic [IW-1:0] link;
        logic [LW-1:0] lvl;
    } t_thr_word;

    typedef enum logic [2:0] {
        S_IDLE, S_CUR, S_APP, S_POP, S_HEAD, S_LINK, S_EMIT
    } t_state;

    // Map a thread id onto a thread memory address
    function automatic logic [TW-1:0] to_tidx(input logic [IW-1:0] id);
        logic [TW+IW-1:0] w;
        w = {{TW{1'b0}}, id};
        return w[TW-1:0];
    endfunction

    // Memories
    t_lvl_word r_lvl_mem [LEVELS];
    t_thr_word r_thr_mem [THREADS];
    t_lvl_word r_lvl_rd;
    t_thr_word r_thr_rd;

    // Control and working registers
    t_state              r_state, n_state;
    logic [LEVELS-1:0]   r_bits, n_bits;
    logic [IW-1:0]       r_cur, n_cur;
    logic                r_cur_vld, n_cur_vld;
    logic [IW-1:0]       r_tid, n_tid;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic                r_yield, n_yield;
    logic                r_after, n_after;
    prq_pkg::t_status    r_res_st, n_res_st;
    logic [IW-1:0]       r_res_thr, n_res_thr;
    logic                r_res_vld, n_res_vld;
    logic                r_o_valid, n_o_valid;
    logic [prq_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic [IW-1:0]       r_o_thr, n_o_thr;
    logic                r_o_tvld, n_o_tvld;

    // Memory port controls
    logic [LW-1:0]       lvl_raddr, lvl_waddr;
    logic                lvl_we_head, lvl_we_tail;
    logic [IW-1:0]       lvl_wd_head, lvl_wd_tail;
    logic [TW-1:0]       thr_raddr, thr_waddr;
    logic                thr_we_link, thr_we_lvl;
    logic [IW-1:0]       thr_wd_link;
    logic [LW-1:0]       thr_wd_lvl;

    // Most urgent ready level
    logic [LW-1:0]       best_idx;
    logic                best_none;

    logic                cmd_fire;
    logic [LW-1:0]       cmd_lvl;
    logic                cmd_in_range;

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign cmd_fire          = i_cmd.valid && (r_state == S_IDLE);
    assign cmd_lvl           = i_cmd.priority_req[LW-1:0];
    assign cmd_in_range      = (32'(i_cmd.thread_id) < THREADS)
                            && (32'(i_cmd.priority_req) < LEVELS);

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.next_thread  = r_o_thr;
    assign o_rsp.thread_valid = r_o_tvld;

    // Priority-encode the ready bitmap, lowest level wins
    always_comb begin
        best_idx = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_bits[l]) begin
                best_idx = LW'(l);
            end
        end
        best_none = ~|r_bits;
    end

    // Sequencer: read, modify and write back the queue memories
    always_comb begin
        n_state    = r_state;
        n_bits     = r_bits;
        n_cur      = r_cur;
        n_cur_vld  = r_cur_vld;
        n_tid      = r_tid;
        n_lvl      = r_lvl;
        n_yield    = r_yield;
        n_after    = r_after;
        n_res_st   = r_res_st;
        n_res_thr  = r_res_thr;
        n_res_vld  = r_res_vld;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_thr    = r_o_thr;
        n_o_tvld   = r_o_tvld;

        lvl_raddr   = r_lvl;
        lvl_waddr   = r_lvl;
        lvl_we_head = 1'b0;
        lvl_we_tail = 1'b0;
        lvl_wd_head = r_tid;
        lvl_wd_tail = r_tid;
        thr_raddr   = to_tidx(r_cur);
        thr_waddr   = to_tidx(r_lvl_rd.tail);
        thr_we_link = 1'b0;
        thr_we_lvl  = 1'b0;
        thr_wd_link = r_tid;
        thr_wd_lvl  = cmd_lvl;

        // Retire the output beat
        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    if (i_cmd.operation == prq_pkg::OP_READY) begin
                        if (cmd_in_range) begin
                            // Record the level and fetch its tail
                            lvl_raddr  = cmd_lvl;
                            thr_waddr  = to_tidx(i_cmd.thread_id);
                            thr_we_lvl = 1'b1;
                            n_tid      = i_cmd.thread_id;
                            n_lvl      = cmd_lvl;
                            n_after    = 1'b0;
                            n_state    = S_APP;
                        end else begin
                            n_res_st  = prq_pkg::ST_READY;
                            n_res_thr = '0;
                            n_res_vld = 1'b0;
                            n_state   = S_EMIT;
                        end
                    end else if (i_cmd.sched_locked) begin
                        n_res_st  = prq_pkg::ST_LOCKED;
                        n_res_thr = '0;
                        n_res_vld = 1'b0;
                        n_state   = S_EMIT;
                    end else if (r_cur_vld && i_cmd.current_running) begin
                        // Fetch the level of the current thread
                        thr_raddr = to_tidx(r_cur);
                        n_yield   = i_cmd.yield;
                        n_state   = S_CUR;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end

            S_CUR: begin
                if (!r_yield && (best_none || (r_thr_rd.lvl <= best_idx))) begin
                    n_res_st  = prq_pkg::ST_KEPT;
                    n_res_thr = r_cur;
                    n_res_vld = 1'b1;
                    n_state   = S_EMIT;
                end else begin
                    // Requeue the current thread at its tail
                    lvl_raddr = r_thr_rd.lvl;
                    n_tid     = r_cur;
                    n_lvl     = r_thr_rd.lvl;
                    n_after   = 1'b1;
                    n_state   = S_APP;
                end
            end

            S_APP: begin
                // Link behind the old tail or start a new list
                if (r_bits[r_lvl]) begin
                    thr_waddr   = to_tidx(r_lvl_rd.tail);
                    thr_we_link = 1'b1;
                end else begin
                    lvl_we_head = 1'b1;
                end
                lvl_we_tail    = 1'b1;
                n_bits[r_lvl]  = 1'b1;
                if (r_after) begin
                    n_state = S_POP;
                end else begin
                    n_res_st  = prq_pkg::ST_READY;
                    n_res_thr = '0;
                    n_res_vld = 1'b0;
                    n_state   = S_EMIT;
                end
            end

            S_POP: begin
                if (best_none) begin
                    n_cur     = '0;
                    n_cur_vld = 1'b0;
                    n_res_st  = prq_pkg::ST_IDLE;
                    n_res_thr = '0;
                    n_res_vld = 1'b0;
                    n_state   = S_EMIT;
                end else begin
                    lvl_raddr = best_idx;
                    n_lvl     = best_idx;
                    n_state   = S_HEAD;
                end
            end

            S_HEAD: begin
                n_cur     = r_lvl_rd.head;
                n_cur_vld = 1'b1;
                if (r_lvl_rd.tail == r_lvl_rd.head) begin
                    // Last entry: drop the level
                    n_bits[r_lvl] = 1'b0;
                    n_res_st      = prq_pkg::ST_SWITCHED;
                    n_res_thr     = r_lvl_rd.head;
                    n_res_vld     = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    thr_raddr = to_tidx(r_lvl_rd.head);
                    n_state   = S_LINK;
                end
            end

            S_LINK: begin
                // Advance the head along its link
                lvl_we_head = 1'b1;
                lvl_wd_head = r_thr_rd.link;
                n_res_st    = prq_pkg::ST_SWITCHED;
                n_res_thr   = r_cur;
                n_res_vld   = 1'b1;
                n_state     = S_EMIT;
            end

            S_EMIT: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_st;
                    n_o_thr    = r_res_thr;
                    n_o_tvld   = r_res_vld;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bits    <= '0;
            r_cur     <= '0;
            r_cur_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bits    <= n_bits;
            r_cur     <= n_cur;
            r_cur_vld <= n_cur_vld;
            r_o_valid <= n_o_valid;
        end
        r_tid      <= n_tid;
        r_lvl      <= n_lvl;
        r_yield    <= n_yield;
        r_after    <= n_after;
        r_res_st   <= n_res_st;
        r_res_thr  <= n_res_thr;
        r_res_vld  <= n_res_vld;
        r_o_status <= n_o_status;
        r_o_thr    <= n_o_thr;
        r_o_tvld   <= n_o_tvld;
    end

    // Level memory: head and tail per level
    always_ff @(posedge i_clk) begin
        if (lvl_we_head) begin
            r_lvl_mem[lvl_waddr].head <= lvl_wd_head;
        end
        if (lvl_we_tail) begin
            r_lvl_mem[lvl_waddr].tail <= lvl_wd_tail;
        end
        r_lvl_rd <= r_lvl_mem[lvl_raddr];
    end

    // Thread memory: link and level per thread
    always_ff @(posedge i_clk) begin
        if (thr_we_link) begin
            r_thr_mem[thr_waddr].link <= thr_wd_link;
        end
        if (thr_we_lvl) begin
            r_thr_mem[thr_waddr].lvl <= thr_wd_lvl;
        end
        r_thr_rd <= r_thr_mem[thr_raddr];
    end

endmodule

// File: rtl/prq_checker.sv
// Port-level assertions for the priority run-queue scheduler, with their bind.
module prq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [prq_pkg::STATUS_W-1:0]  i_rsp_status,
    input logic [prq_pkg::ID_W-1:0]      i_rsp_thread,
    input logic                          i_rsp_tvld
);

    // A stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid
            && $stable(i_rsp_status) && $stable(i_rsp_thread) && $stable(i_rsp_tvld))
        else $error("response beat changed while stalled");

    // One command at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command accepted while another is in work");

    // Thread flag matches the status
    a_tvld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_tvld == ((i_rsp_status == prq_pkg::ST_KEPT)
            || (i_rsp_status == prq_pkg::ST_SWITCHED))))
        else $error("thread_valid does not match status");

    // No thread is named without thread_valid
    a_zero_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_tvld |-> i_rsp_thread == '0)
        else $error("next_thread set without thread_valid");

endmodule

bind priority_run_queue_scheduler prq_checker u_prq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_thread (o_rsp.next_thread),
    .i_rsp_tvld   (o_rsp.thread_valid)
);

// File: dv/priority_run_queue_scheduler_tb.sv
// Self-checking testbench of the priority run-queue scheduler: directed and random traffic.
module priority_run_queue_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prq_pkg::*;

    localparam int NUM_LEVELS   = LEVELS_DEF;
    localparam int NUM_THREADS  = THREADS_DEF;
    localparam int RANDOM_CMDS  = 1225;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int NO_LEVEL     = 32;

    typedef struct packed {
        bit              operation;
        bit [ID_W-1:0]   thread_id;
        bit [PRIO_W-1:0] priority_req;
        bit              yield;
        bit              sched_locked;
        bit              current_running;
    } sched_cmd_t;

    typedef struct packed {
        t_status       status;
        bit [ID_W-1:0] next_thread;
        bit            thread_valid;
    } sched_rsp_t;

    // Scheduler shadow: run queues, current thread and the outcomes still owed by the block
    class run_queue_scoreboard;
        bit [31:0]       ready_map;
        bit [ID_W-1:0]   head_of[NUM_LEVELS];
        bit [ID_W-1:0]   tail_of[NUM_LEVELS];
        bit [ID_W-1:0]   link_of[NUM_THREADS];
        bit [PRIO_W-1:0] level_of[NUM_THREADS];
        bit [ID_W-1:0]   cur_thread;
        bit              cur_valid;
        bit [NUM_THREADS-1:0] in_play;
        sched_rsp_t      sched_outcomes[$];
        int mismatches;
        int results_seen;
        int n_ready, n_locked, n_kept, n_switched, n_idle;

        function new();
            ready_map  = '0;
            cur_thread = '0;
            cur_valid  = 1'b0;
            in_play    = '0;
            mismatches = 0;
            results_seen = 0;
            n_ready = 0; n_locked = 0; n_kept = 0; n_switched = 0; n_idle = 0;
        endfunction

        // Level L sits at bitmap bit 31-L; scan from the most urgent
        function int top_level();
            for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
                if (ready_map[31-lvl]) return lvl;
            end
            return NO_LEVEL;
        endfunction

        // Link a thread behind the tail of its level
        function void push_tail(bit [ID_W-1:0] tid, bit [PRIO_W-1:0] lvl);
            if (ready_map[31-lvl]) link_of[tail_of[lvl]] = tid;
            else head_of[lvl] = tid;
            tail_of[lvl] = tid;
            ready_map[31-lvl] = 1'b1;
        endfunction

        // Unlink the head; the level empties when head meets tail
        function bit [ID_W-1:0] pop_front(int lvl);
            bit [ID_W-1:0] h;
            h = head_of[lvl];
            if (tail_of[lvl] == h) ready_map[31-lvl] = 1'b0;
            else head_of[lvl] = link_of[h];
            return h;
        endfunction

        function sched_rsp_t schedule(sched_cmd_t c);
            sched_rsp_t r;
            bit kept;
            int best;
            r = '{status: ST_LOCKED, next_thread: '0, thread_valid: 1'b0};
            kept = 1'b0;
            if (c.operation == OP_READY) begin
                level_of[c.thread_id] = c.priority_req;
                push_tail(c.thread_id, c.priority_req);
                in_play[c.thread_id] = 1'b1;
                r.status = ST_READY;
            end else if (!c.sched_locked) begin
                // Keep or requeue a running current thread
                if (cur_valid && c.current_running) begin
                    if (!c.yield && int'(level_of[cur_thread]) <= top_level()) kept = 1'b1;
                    else push_tail(cur_thread, level_of[cur_thread]);
                end else if (cur_valid) begin
                    in_play[cur_thread] = 1'b0;
                end
                if (kept) begin
                    r = '{status: ST_KEPT, next_thread: cur_thread, thread_valid: 1'b1};
                end else begin
                    best = top_level();
                    if (best >= NUM_LEVELS) begin
                        cur_valid  = 1'b0;
                        cur_thread = '0;
                        r.status   = ST_IDLE;
                    end else begin
                        cur_thread = pop_front(best);
                        cur_valid  = 1'b1;
                        r = '{status: ST_SWITCHED, next_thread: cur_thread, thread_valid: 1'b1};
                    end
                end
            end
            return r;
        endfunction

        function void note_command(sched_cmd_t c);
            sched_outcomes.push_back(schedule(c));
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] next_thread,
                                   logic thread_valid);
            sched_rsp_t exp_rsp;
            results_seen++;
            if (sched_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %0d: status %0d thread %0d valid %0b",
                             results_seen, status, next_thread, thread_valid);
                return;
            end
            exp_rsp = sched_outcomes.pop_front();
            if (status !== exp_rsp.status || next_thread !== exp_rsp.next_thread ||
                    thread_valid !== exp_rsp.thread_valid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: exp st %0d thr %0d vld %0b, got st %0d thr %0d vld %0b",
                             results_seen, exp_rsp.status, exp_rsp.next_thread,
                             exp_rsp.thread_valid, status, next_thread, thread_valid);
            end
            case (exp_rsp.status)
                ST_READY:    n_ready++;
                ST_LOCKED:   n_locked++;
                ST_KEPT:     n_kept++;
                ST_SWITCHED: n_switched++;
                default:     n_idle++;
            endcase
        endfunction

        function int pending();
            return sched_outcomes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt = 0;
    int   burst_left;

    prq_cmd_if cmd_if ();
    prq_rsp_if rsp_if ();

    run_queue_scoreboard sb = new();

    priority_run_queue_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Clock: 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[priority_run_queue_scheduler] ERROR");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Check every result beat against the oldest outstanding outcome
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_result(rsp_if.status, rsp_if.next_thread, rsp_if.thread_valid);
    end

    // Output backpressure: runs of ready, then stalls of random length
    initial begin
        int run_len;
        int stall;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= 1'b1;
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
            repeat (run_len) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end
        end
    end

    // Drive one command beat and hold it until taken
    task automatic issue_cmd(input sched_cmd_t c);
        cmd_if.valid           <= 1'b1;
        cmd_if.operation       <= c.operation;
        cmd_if.thread_id       <= c.thread_id;
        cmd_if.priority_req    <= c.priority_req;
        cmd_if.yield           <= c.yield;
        cmd_if.sched_locked    <= c.sched_locked;
        cmd_if.current_running <= c.current_running;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        sb.note_command(c);
    endtask

    // Drop valid for a random gap, except inside a back-to-back burst
    task automatic idle_between();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        if ($urandom_range(0, 49) == 0) begin
            burst_left = $urandom_range(20, 60);
            return;
        end
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send(input bit op, input int tid, input int prio, input bit y,
                        input bit lck, input bit run);
        issue_cmd('{operation: op, thread_id: tid[ID_W-1:0], priority_req: prio[PRIO_W-1:0],
                    yield: y, sched_locked: lck, current_running: run});
        idle_between();
    endtask

    // Mostly a plausible OS pattern: ready threads that are blocked, select with them
    function automatic sched_cmd_t next_random_cmd();
        sched_cmd_t c;
        int r;
        c.operation       = OP_SELECT;
        c.thread_id       = ID_W'($urandom_range(0, NUM_THREADS - 1));
        c.priority_req    = PRIO_W'($urandom_range(0, 31));
        c.yield           = 1'($urandom_range(0, 1));
        c.sched_locked    = 1'($urandom_range(0, 1));
        c.current_running = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 45) begin
            c.operation = OP_READY;
            // Prefer a thread that is neither queued nor current; a few duplicates stay as noise
            if (r >= 5) begin
                for (int t = 0; t < 8 && sb.in_play[c.thread_id]; t++)
                    c.thread_id = ID_W'($urandom_range(0, NUM_THREADS - 1));
            end
            if ($urandom_range(0, 1) == 1) c.priority_req = PRIO_W'($urandom_range(0, 3));
        end else begin
            c.sched_locked    = ($urandom_range(0, 9) == 0);
            c.current_running = ($urandom_range(0, 9) < 7);
            c.yield           = ($urandom_range(0, 3) == 0);
        end
        return c;
    endfunction

    initial begin
        burst_left = 0;
        i_rst_n    = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.operation       = OP_SELECT;
        cmd_if.thread_id       = '0;
        cmd_if.priority_req    = '0;
        cmd_if.yield           = 1'b0;
        cmd_if.sched_locked    = 1'b0;
        cmd_if.current_running = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle at reset, lock, extremes, keep, yield, preempt, duplicates, drain
        send(OP_SELECT, 0, 0, 1, 0, 1);     // no current thread, empty bitmap: idle
        send(OP_SELECT, 0, 0, 1, 1, 1);     // locked
        send(OP_READY,  0, 0, 0, 0, 0);
        send(OP_READY, 31, 31, 0, 0, 0);
        send(OP_READY,  5, 31, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 0);     // take thread 0
        send(OP_SELECT, 0, 0, 0, 0, 1);     // keep thread 0
        send(OP_SELECT, 0, 0, 1, 0, 1);     // yield, same thread comes back
        send(OP_READY,  7, 0, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 1);     // equal level ready: keep
        send(OP_SELECT, 0, 0, 1, 0, 1);     // yield behind thread 7
        send(OP_SELECT, 0, 0, 0, 0, 0);     // thread 7 blocks
        send(OP_SELECT, 0, 0, 0, 0, 0);     // thread 0 blocks, least urgent level
        send(OP_READY, 12, 16, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 1);     // preempt by a more urgent level
        send(OP_SELECT, 0, 0, 1, 1, 1);     // locked while others wait
        send(OP_READY, 12, 16, 0, 0, 0);    // ready the current thread again
        send(OP_SELECT, 0, 0, 0, 0, 1);
        send(OP_SELECT, 0, 0, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 0);     // drained: idle
        send(OP_SELECT, 0, 0, 1, 0, 1);     // still no current thread
        send(OP_READY, 21, 10, 1, 1, 1);    // select-only fields set on a ready
        send(OP_SELECT, 0, 0, 0, 0, 1);

        // Random traffic
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            issue_cmd(next_random_cmd());
            idle_between();
        end
        cmd_if.valid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d results: %0d ready, %0d locked, %0d kept, %0d switched, %0d idle",
                 sb.results_seen, sb.n_ready, sb.n_locked, sb.n_kept, sb.n_switched, sb.n_idle);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[priority_run_queue_scheduler] OK");
        end else begin
            $display("[priority_run_queue_scheduler] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/prq_pkg.sv
rtl/prq_cmd_if.sv
rtl/priority_run_queue_scheduler.sv
rtl/prq_checker.sv
dv/priority_run_queue_scheduler_tb.sv
